// ----- hw/rtl/pgl_pkg.sv -----
// Shared types, constants and helpers for the Poisson guidance Laplacian block.
package pgl_pkg;

   localparam int PIXEL_BITS         = 8;
   localparam int GUIDE_BITS         = 12;
   localparam int SUM_BITS           = GUIDE_BITS + 2;
   localparam int CSR_INDEX_BITS     = 2;
   localparam int CSR_DATA_BITS      = 9;
   localparam int DEFAULT_MAX_WIDTH  = 256;
   localparam int DEFAULT_MAX_HEIGHT = 256;

   localparam logic [CSR_DATA_BITS-1:0]  REGION_RESET      = CSR_DATA_BITS'(256);
   localparam logic [CSR_INDEX_BITS-1:0] CSR_REGION_WIDTH  = CSR_INDEX_BITS'(0);
   localparam logic [CSR_INDEX_BITS-1:0] CSR_REGION_HEIGHT = CSR_INDEX_BITS'(1);

   typedef struct packed {
      logic [PIXEL_BITS-1:0] front_pixel;
      logic [PIXEL_BITS-1:0] back_pixel;
      logic                  mask_set;
   } req_word_type;

   typedef struct packed {
      logic signed [GUIDE_BITS-1:0] guidance_value;
      logic                         last_of_region;
   } rsp_word_type;

   typedef struct packed {
      logic                  mask;
      logic [PIXEL_BITS-1:0] back;
      logic [PIXEL_BITS-1:0] front;
   } sample_type;

   // One line-store entry holds the same column of the two previous rows.
   typedef struct packed {
      sample_type line0;
      sample_type line1;
   } line_entry_type;

   // Position of the pixel being finished, decoded when its word is taken in.
   typedef struct packed {
      logic produce;
      logic first_row;
      logic last_row;
      logic first_col;
      logic last_col;
   } pos_flags_type;

   // Effective region size: zero acts as one, anything above the maximum as the maximum.
   function automatic int eff_dim(logic [CSR_DATA_BITS-1:0] v, int maxv);
      if (v == '0) return 1;
      if (int'(v) > maxv) return maxv;
      return int'(v);
   endfunction

endpackage

// ----- hw/rtl/poisson_guidance_laplacian.sv -----
// Top level of the Poisson guidance Laplacian block.
//
// The req channel takes one word per padded window position, raster order,
// (region_height+2) rows of (region_width+2) columns, carrying the front
// sample, the back sample and the mask bit. For every region pixel the rsp
// channel gives one word: the guidance value and a flag on the last pixel.
// The result for a pixel is produced by the word south-east of it, so the
// first two padded rows and the first two columns of each row give no result.
// The csr channel writes region_width (index 0) or region_height (index 1);
// any write to these restarts the pass at the top-left corner. It is always
// ready; the user must use it only while the block is idle (not enforced).
// A taken word passes the in-flight register and the result queue to rsp.
// Throughput: one word per cycle while req_ready is high; the line store is
// read when a word is taken and written back in the cycle after, and
// successive words always touch different columns, so reads and write-backs
// never meet on one entry. A four-word result queue sits before rsp; req_ready
// drops only when that queue plus the word in flight would overflow and never
// looks at rsp_ready, so a stalled receiver holds its word and req backs up within three words.
// Reset clears counters, queue and window and sets both sizes to 256; the
// line store is not cleared, since the first two rows of a pass refill it.
module poisson_guidance_laplacian #(
   parameter int MAX_WIDTH  = pgl_pkg::DEFAULT_MAX_WIDTH,
   parameter int MAX_HEIGHT = pgl_pkg::DEFAULT_MAX_HEIGHT
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   output logic                                 req_ready,
   input  pgl_pkg::req_word_type                req_word,
   output logic                                 rsp_valid,
   input  logic                                 rsp_ready,
   output pgl_pkg::rsp_word_type                rsp_word,
   input  logic                                 csr_valid,
   output logic                                 csr_ready,
   input  logic [pgl_pkg::CSR_INDEX_BITS-1:0]   csr_index,
   input  logic [pgl_pkg::CSR_DATA_BITS-1:0]    csr_wdata
);

   localparam int LINE_LEN = MAX_WIDTH + 2;
   localparam int CW       = $clog2(MAX_WIDTH + 2);
   localparam int RW       = $clog2(MAX_HEIGHT + 2);

   // Effective sizes after clamping, and the padded position of the next word.
   logic [CW-1:0] eff_w_ff, eff_w_in;
   logic [RW-1:0] eff_h_ff, eff_h_in;
   logic [CW-1:0] col_ff, col_in;
   logic [RW-1:0] row_ff, row_in;

   // Word in flight between the line-store read and its write-back.
   logic                   s1_valid_ff, s1_valid_in;
   logic [CW-1:0]          s1_col_ff;
   pgl_pkg::pos_flags_type s1_flags_ff, flags_in;
   pgl_pkg::sample_type    s1_sample_ff, sample_in;

   logic                    accept;
   logic                    pop;
   logic                    push;
   logic [2:0]              fifo_count;
   logic [2:0]              occupancy;
   logic                    last_col_now;
   logic                    last_row_now;
   pgl_pkg::line_entry_type rd_entry;
   pgl_pkg::line_entry_type wr_entry;
   pgl_pkg::rsp_word_type   push_word;

   assign csr_ready = 1'b1;
   assign accept    = req_valid & req_ready;
   assign pop       = rsp_valid & rsp_ready;

   // The queue may hold four words; count the one in flight against it.
   assign occupancy = fifo_count + {2'b00, s1_valid_ff};
   assign req_ready = (occupancy < 3'd4);

   assign last_col_now = (col_ff == eff_w_ff + CW'(1));
   assign last_row_now = (row_ff == eff_h_ff + RW'(1));

   always_comb begin
      flags_in.produce   = (row_ff >= RW'(2)) && (col_ff >= CW'(2));
      flags_in.first_row = (row_ff == RW'(2));
      flags_in.last_row  = last_row_now;
      flags_in.first_col = (col_ff == CW'(2));
      flags_in.last_col  = last_col_now;
      sample_in.mask  = req_word.mask_set;
      sample_in.back  = req_word.back_pixel;
      sample_in.front = req_word.front_pixel;
   end

   always_comb begin
      eff_w_in    = eff_w_ff;
      eff_h_in    = eff_h_ff;
      col_in      = col_ff;
      row_in      = row_ff;
      s1_valid_in = accept;
      if (accept) begin
         if (last_col_now) begin
            col_in = '0;
            row_in = last_row_now ? '0 : row_ff + RW'(1);
         end else begin
            col_in = col_ff + CW'(1);
         end
      end
      if (csr_valid && (csr_index == pgl_pkg::CSR_REGION_WIDTH)) begin
         eff_w_in = CW'(pgl_pkg::eff_dim(csr_wdata, MAX_WIDTH));
         col_in   = '0;
         row_in   = '0;
      end else if (csr_valid && (csr_index == pgl_pkg::CSR_REGION_HEIGHT)) begin
         eff_h_in = RW'(pgl_pkg::eff_dim(csr_wdata, MAX_HEIGHT));
         col_in   = '0;
         row_in   = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         eff_w_ff    <= CW'(pgl_pkg::eff_dim(pgl_pkg::REGION_RESET, MAX_WIDTH));
         eff_h_ff    <= RW'(pgl_pkg::eff_dim(pgl_pkg::REGION_RESET, MAX_HEIGHT));
         col_ff      <= '0;
         row_ff      <= '0;
         s1_valid_ff <= 1'b0;
      end else begin
         eff_w_ff    <= eff_w_in;
         eff_h_ff    <= eff_h_in;
         col_ff      <= col_in;
         row_ff      <= row_in;
         s1_valid_ff <= s1_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         s1_col_ff    <= col_ff;
         s1_flags_ff  <= flags_in;
         s1_sample_ff <= sample_in;
      end
   end

   pgl_line_mem #(
      .DEPTH     (LINE_LEN),
      .ADDR_BITS (CW)
   ) u_line_mem (
      .clock   (clock),
      .rd_en   (accept),
      .rd_addr (col_ff),
      .rd_data (rd_entry),
      .wr_en   (s1_valid_ff),
      .wr_addr (s1_col_ff),
      .wr_data (wr_entry)
   );

   pgl_window u_window (
      .clock     (clock),
      .reset     (reset),
      .s1_valid  (s1_valid_ff),
      .s1_flags  (s1_flags_ff),
      .s1_sample (s1_sample_ff),
      .rd_entry  (rd_entry),
      .wr_entry  (wr_entry),
      .push      (push),
      .push_word (push_word)
   );

   pgl_rsp_fifo u_rsp_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_word (push_word),
      .pop       (pop),
      .rsp_valid (rsp_valid),
      .rsp_word  (rsp_word),
      .count     (fifo_count)
   );

endmodule

// ----- hw/rtl/pgl_line_mem.sv -----
// Two-line sample store: one synchronous memory, one read and one write port.
module pgl_line_mem #(
   parameter int DEPTH     = pgl_pkg::DEFAULT_MAX_WIDTH + 2,
   parameter int ADDR_BITS = $clog2(pgl_pkg::DEFAULT_MAX_WIDTH + 2)
) (
   input  logic                     clock,
   input  logic                     rd_en,
   input  logic [ADDR_BITS-1:0]     rd_addr,
   output pgl_pkg::line_entry_type  rd_data,
   input  logic                     wr_en,
   input  logic [ADDR_BITS-1:0]     wr_addr,
   input  pgl_pkg::line_entry_type  wr_data
);

   pgl_pkg::line_entry_type mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data <= mem_ff[rd_addr];
      end
   end

endmodule

// ----- hw/rtl/pgl_window.sv -----
// Window registers, line-store write-back data and the guidance value arithmetic.
module pgl_window (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     s1_valid,
   input  pgl_pkg::pos_flags_type   s1_flags,
   input  pgl_pkg::sample_type      s1_sample,
   input  pgl_pkg::line_entry_type  rd_entry,
   output pgl_pkg::line_entry_type  wr_entry,
   output logic                     push,
   output pgl_pkg::rsp_word_type    push_word
);

   localparam int SB = pgl_pkg::SUM_BITS;
   localparam int GB = pgl_pkg::GUIDE_BITS;
   localparam logic signed [SB-1:0] SAT_HI = SB'((2 ** (GB - 1)) - 1);
   localparam logic signed [SB-1:0] SAT_LO = -SB'(2 ** (GB - 1));

   // Newest column (north, center, south rows) and the center of the column before.
   pgl_pkg::sample_type col_n_ff, col_c_ff, col_s_ff, west_ff;
   pgl_pkg::sample_type col_n_in, col_c_in, col_s_in, west_in;

   logic signed [SB-1:0] v_n, v_s, v_w, v_e, v_c;
   logic signed [SB-1:0] b_n, b_s, b_w, b_e;
   logic signed [SB-1:0] lap, edge_row, edge_col, total;
   logic                 use_front;

   always_comb begin
      col_n_in = col_n_ff;
      col_c_in = col_c_ff;
      col_s_in = col_s_ff;
      west_in  = west_ff;
      if (s1_valid) begin
         west_in  = col_c_ff;
         col_n_in = rd_entry.line0;
         col_c_in = rd_entry.line1;
         col_s_in = s1_sample;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_n_ff <= '0;
         col_c_ff <= '0;
         col_s_ff <= '0;
         west_ff  <= '0;
      end else begin
         col_n_ff <= col_n_in;
         col_c_ff <= col_c_in;
         col_s_ff <= col_s_in;
         west_ff  <= west_in;
      end
   end

   // The row above moves up one line; the new sample becomes the newer line.
   assign wr_entry.line0 = rd_entry.line1;
   assign wr_entry.line1 = s1_sample;

   // Before this word's shift: center, north and south come from the newest
   // column held, west is the column before, east the freshly read middle line.
   always_comb begin
      use_front = col_c_ff.mask;
      v_n = $signed(SB'(use_front ? col_n_ff.front : col_n_ff.back));
      v_s = $signed(SB'(use_front ? col_s_ff.front : col_s_ff.back));
      v_w = $signed(SB'(use_front ? west_ff.front : west_ff.back));
      v_e = $signed(SB'(use_front ? rd_entry.line1.front : rd_entry.line1.back));
      v_c = $signed(SB'(use_front ? col_c_ff.front : col_c_ff.back));
      b_n = $signed(SB'(col_n_ff.back));
      b_s = $signed(SB'(col_s_ff.back));
      b_w = $signed(SB'(west_ff.back));
      b_e = $signed(SB'(rd_entry.line1.back));

      lap = v_n + v_s + v_w + v_e - (v_c <<< 2);

      if (s1_flags.first_row)     edge_row = b_n;
      else if (s1_flags.last_row) edge_row = b_s;
      else                        edge_row = '0;

      if (s1_flags.first_col)     edge_col = b_w;
      else if (s1_flags.last_col) edge_col = b_e;
      else                        edge_col = '0;

      total = lap - edge_row - edge_col;

      if (total > SAT_HI)      push_word.guidance_value = SAT_HI[GB-1:0];
      else if (total < SAT_LO) push_word.guidance_value = SAT_LO[GB-1:0];
      else                     push_word.guidance_value = total[GB-1:0];
      push_word.last_of_region = s1_flags.last_row & s1_flags.last_col;
   end

   assign push = s1_valid & s1_flags.produce;

endmodule

// ----- hw/rtl/pgl_rsp_fifo.sv -----
// Four-entry result queue that decouples the pipeline from the receiver.
module pgl_rsp_fifo (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  push,
   input  pgl_pkg::rsp_word_type push_word,
   input  logic                  pop,
   output logic                  rsp_valid,
   output pgl_pkg::rsp_word_type rsp_word,
   output logic [2:0]            count
);

   pgl_pkg::rsp_word_type entry_ff [4];
   logic [1:0] wr_ptr_ff, wr_ptr_in;
   logic [1:0] rd_ptr_ff, rd_ptr_in;
   logic [2:0] count_ff, count_in;

   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + 2'd1 : wr_ptr_ff;
      rd_ptr_in = pop ? rd_ptr_ff + 2'd1 : rd_ptr_ff;
      count_in  = count_ff + {2'b00, push} - {2'b00, pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 2'd0;
         rd_ptr_ff <= 2'd0;
         count_ff  <= 3'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_word;
      end
   end

   assign rsp_valid = (count_ff != 3'd0);
   assign rsp_word  = entry_ff[rd_ptr_ff];
   assign count     = count_ff;

endmodule

// ----- hw/rtl/pgl_checker.sv -----
// Port-level checks for the Poisson guidance Laplacian block, bound to the top level.
module pgl_checker (
   input logic                  clock,
   input logic                  reset,
   input logic                  req_valid,
   input logic                  req_ready,
   input logic                  rsp_valid,
   input logic                  rsp_ready,
   input pgl_pkg::rsp_word_type rsp_word
);

   // A waiting result word stays offered.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("rsp_valid dropped before the word was taken");

   // A waiting result word does not change.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> $stable(rsp_word))
      else $error("rsp_word changed while stalled");

   // A rising rsp_valid must follow a word taken in earlier on req.
   assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(req_valid && req_ready, 2))
      else $error("result appeared without a word taken two cycles earlier");

   // Nothing is offered right after reset.
   assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result offered right after reset");

   // Eight-bit samples keep the guidance value inside -1530 to 1020.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> ((rsp_word.guidance_value >= -12'sd1530) &&
                     (rsp_word.guidance_value <= 12'sd1020)))
      else $error("guidance value out of range");

endmodule

bind poisson_guidance_laplacian pgl_checker u_pgl_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_valid),
   .req_ready (req_ready),
   .rsp_valid (rsp_valid),
   .rsp_ready (rsp_ready),
   .rsp_word  (rsp_word)
);
